@@ rtl/ppbc_pkg.sv @@
// Package with the item types, operation codes and register indexes of the permutation pad cipher.
package ppbc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned TABLE_W = 40;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned LANES   = 16;

    localparam logic [OP_W-1:0] OP_LOAD_SEED = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCRYPT   = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 1'd1;

    // Identity permutation for every pad.
    localparam logic [TABLE_W-1:0] TABLE_RESET = 40'hE4E4E4E4E4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] data_in;
        logic              block_last;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              last_out;
    } out_item_t;

endpackage

@@ rtl/permutation_pad_block_cipher.sv @@
// Top level of the permutation pad block cipher with 2-bit lanes.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid / s_ready  ppbc_pkg::in_item_t  (operation, data_in, block_last)
//  m_       out        m_valid / m_ready  ppbc_pkg::out_item_t (data_out, last_out)
//  cfg_     in         cfg_we             cfg_index selects the table, cfg_wdata holds it
//
// One item is accepted per cycle while s_ready is high. An encrypt or decrypt item
// goes from the input register, which takes it at the edge that accepts it, to the
// result register, which drives m_valid; the LFSR step is combinational ahead of the
// input register and the lane lookups are combinational between the two registers.
// Reset (aresetn low at a clock edge) clears the LFSR and restores identity tables.
// A stall on m_ready backs up through the input register and then drops s_ready.
module permutation_pad_block_cipher #(
    parameter int unsigned PADS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ppbc_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ppbc_pkg::out_item_t                 m_item,
    input  logic                                cfg_we,
    input  logic [ppbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppbc_pkg::TABLE_W-1:0]        cfg_wdata
);

    // Lane pad value to pad number (pad value modulo PADS), worked out at elaboration.
    logic [2:0] pad_map [4];

    for (genvar v = 0; v < 4; v++) begin : g_pad_map
        localparam int unsigned PAD_IDX = v % PADS;
        assign pad_map[v] = 3'(PAD_IDX);
    end

    // Configuration tables.
    logic [ppbc_pkg::TABLE_W-1:0] fwd_table_reg;
    logic [ppbc_pkg::TABLE_W-1:0] inv_table_reg;

    // LFSR that produces one pad word per cipher item.
    logic [ppbc_pkg::DATA_W-1:0] lfsr_reg;
    logic [ppbc_pkg::DATA_W-1:0] lfsr_next;
    logic [ppbc_pkg::DATA_W-1:0] lfsr_step;

    // Input register: the block, its pad word and the direction.
    logic                        st1_valid_reg;
    logic                        st1_valid_next;
    logic                        st1_encrypt_reg;
    logic [ppbc_pkg::DATA_W-1:0] st1_data_reg;
    logic [ppbc_pkg::DATA_W-1:0] st1_pad_reg;
    logic                        st1_last_reg;

    // Result register.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    ppbc_pkg::out_item_t         out_item_reg;
    ppbc_pkg::out_item_t         out_item_next;

    logic s_accept;
    logic is_cipher;
    logic st1_advance;

    assign st1_advance = st1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready     = !st1_valid_reg || st1_advance;
    assign s_accept    = s_valid && s_ready;
    assign is_cipher   = (s_item.operation == ppbc_pkg::OP_ENCRYPT) ||
                         (s_item.operation == ppbc_pkg::OP_DECRYPT);

    // Feedback taps at bits 0, 10, 30 and 31; the register shifts right.
    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[10] ^ lfsr_reg[30] ^ lfsr_reg[31],
                        lfsr_reg[ppbc_pkg::DATA_W-1:1]};

    always_comb begin
        lfsr_next = lfsr_reg;
        if (s_accept) begin
            if (s_item.operation == ppbc_pkg::OP_LOAD_SEED) begin
                lfsr_next = s_item.data_in;
            end else if (is_cipher) begin
                lfsr_next = lfsr_step;
            end
        end
    end

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_accept && is_cipher) begin
            st1_valid_next = 1'b1;
        end else if (st1_advance) begin
            st1_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (st1_advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Sixteen independent lanes. Encrypt looks up forward[p][d ^ x]; decrypt looks up
    // inverse[p][d] and then XORs the pad lane back in.
    always_comb begin
        logic [1:0] lane_d;
        logic [1:0] lane_x;
        logic [1:0] lane_v;
        logic [1:0] lane_r;
        logic [2:0] lane_p;
        logic [5:0] bit_idx;
        out_item_next = out_item_reg;
        out_item_next.last_out = st1_last_reg;
        for (int k = 0; k < ppbc_pkg::LANES; k++) begin
            lane_d  = st1_data_reg[2*k +: 2];
            lane_x  = st1_pad_reg[2*k +: 2];
            lane_p  = pad_map[lane_x];
            lane_v  = st1_encrypt_reg ? (lane_d ^ lane_x) : lane_d;
            bit_idx = {lane_p, 3'b000} + {3'b000, lane_v, 1'b0};
            if (st1_encrypt_reg) begin
                lane_r = fwd_table_reg[bit_idx +: 2];
            end else begin
                lane_r = inv_table_reg[bit_idx +: 2] ^ lane_x;
            end
            out_item_next.data_out[2*k +: 2] = lane_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg      <= '0;
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_table_reg <= ppbc_pkg::TABLE_RESET;
            inv_table_reg <= ppbc_pkg::TABLE_RESET;
        end else begin
            lfsr_reg      <= lfsr_next;
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    ppbc_pkg::CFG_FORWARD: fwd_table_reg <= cfg_wdata;
                    ppbc_pkg::CFG_INVERSE: inv_table_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge aclk) begin
        if (s_accept && is_cipher) begin
            st1_encrypt_reg <= (s_item.operation == ppbc_pkg::OP_ENCRYPT);
            st1_data_reg    <= s_item.data_in;
            st1_pad_reg     <= lfsr_step;
            st1_last_reg    <= s_item.block_last;
        end
        if (st1_advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

@@ rtl/ppbc_checker.sv @@
// Port-level checker of the permutation pad block cipher and its bind statement.
module ppbc_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input ppbc_pkg::out_item_t  m_item
);

    // A result that is not taken stays, unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed or dropped while stalled");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item valid right after reset");

    // With the result side taking items, the input side never stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while the result side is ready");

    // An idle block with nothing accepted shows no new result until it accepts an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !(s_valid && s_ready) ##1 !(s_valid && s_ready) |=> !$rose(m_valid)
            || $past(m_valid, 2) || $past(s_valid && s_ready, 3))
        else $error("result item appeared without an accepted item");

endmodule

bind permutation_pad_block_cipher ppbc_checker u_ppbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

@@ bench/tb.sv @@
// Self-checking testbench for the permutation pad block cipher.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppbc_pkg::*;

    // The cipher is built with four pads, the same as the block's default.
    localparam int unsigned PADS = 4;

    // Operation code 3 is not defined; the block must drop such an item silently.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // The block passes an item through its input register and result register before
    // it raises the result. DRAIN_CYCLES quiet cycles pass after the last result has
    // left, before a table write and before the end of the run, so nothing late can slip by.
    localparam int DRAIN_CYCLES = 8;

    // Far more than the slowest correct run, even with roughly 900 items, each behind a
    // long sender gap and a long receiver stall.
    localparam int TIMEOUT_NS = 10_000_000;

    // One row of the directed part. Where the expected block can be read off at a
    // glance, known is set and want holds it; other rows rely on the predictor.
    typedef struct packed {
        in_item_t          item;
        logic              known;
        logic [DATA_W-1:0] want;
    } dir_row_t;

    localparam int DIR_ROWS = 21;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [TABLE_W-1:0]    cfg_wdata;

    // The predictor's own copy of the cipher state and the two tables.
    logic [DATA_W-1:0]     pad_state    = '0;
    logic [TABLE_W-1:0]    fwd_perm_tbl = TABLE_RESET;
    logic [TABLE_W-1:0]    inv_perm_tbl = TABLE_RESET;

    // Result blocks that the cipher still owes, oldest first.
    out_item_t             pending_blocks[$];
    out_item_t             want_block;

    int                    errors      = 0;
    int                    blocks_sent = 0;
    int                    stall_left  = 0;
    // While steady is set, neither side idles, so the block runs at full rate.
    bit                    steady      = 1'b0;

    dir_row_t              dir_rows [DIR_ROWS];

    permutation_pad_block_cipher #(
        .PADS(PADS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // A 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Prints one line per mismatch and counts it; the run carries on.
    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t ns: %s", $realtime, what);
        errors++;
    endtask

    // Most gaps are zero or short, a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Data and seeds lean toward all zeros and all ones now and then.
    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    function automatic in_item_t make_item(input logic [OP_W-1:0] op,
                                           input logic [DATA_W-1:0] data,
                                           input logic last);
        in_item_t it;
        it.operation  = op;
        it.data_in    = data;
        it.block_last = last;
        return it;
    endfunction

    // One step of the pad generator: taps at bits 0, 10, 30 and 31, shifting right.
    function automatic logic [DATA_W-1:0] lfsr_next(input logic [DATA_W-1:0] s);
        logic fb;
        fb = s[0] ^ s[10] ^ s[30] ^ s[31];
        return {fb, s[DATA_W-1:1]};
    endfunction

    // Entry v of the permutation chosen by a pad lane; each pad holds four 2-bit entries.
    function automatic logic [1:0] perm_lookup(input logic [TABLE_W-1:0] tbl,
                                               input logic [1:0] pad_lane,
                                               input logic [1:0] v);
        int unsigned p;
        p = pad_lane % PADS;
        if (p > 4)
            p = 4;
        return tbl[8*p + 2*v +: 2];
    endfunction

    // Predicts the effect of one accepted item on the cipher and its result block, if any.
    task automatic cipher_step(input in_item_t it, output bit has_res, output out_item_t res);
        logic [1:0] d;
        logic [1:0] x;
        logic [1:0] r;
        int         k;
        has_res = 1'b0;
        res     = '0;
        case (it.operation)
            OP_LOAD_SEED: begin
                pad_state = it.data_in;
            end
            OP_ENCRYPT, OP_DECRYPT: begin
                pad_state = lfsr_next(pad_state);
                for (k = 0; k < LANES; k++) begin
                    d = it.data_in[2*k +: 2];
                    x = pad_state[2*k +: 2];
                    if (it.operation == OP_ENCRYPT)
                        r = perm_lookup(fwd_perm_tbl, x, d ^ x);
                    else
                        r = perm_lookup(inv_perm_tbl, x, d) ^ x;
                    res.data_out[2*k +: 2] = r;
                end
                res.last_out = it.block_last;
                has_res      = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    // Drives one item after a random gap (none while steady) and returns once it is accepted. The valid
    // is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input in_item_t it, input logic known,
                             input logic [DATA_W-1:0] want, output out_item_t res);
        int gap;
        bit has_res;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cipher_step(it, has_res, res);
        if (has_res) begin
            if (known)
                res.data_out = want;
            pending_blocks.push_back(res);
        end
        if (it.operation != OP_RESERVED)
            blocks_sent++;
    endtask

    // Waits until the cipher is idle, then writes both tables.
    task automatic settle_and_configure(input logic [TABLE_W-1:0] fwd,
                                        input logic [TABLE_W-1:0] inv);
        s_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FORWARD;
        cfg_wdata <= fwd;
        @(posedge aclk);
        fwd_perm_tbl = fwd;
        cfg_index <= CFG_INVERSE;
        cfg_wdata <= inv;
        @(posedge aclk);
        inv_perm_tbl = inv;
        cfg_we <= 1'b0;
    endtask

    // A random permutation for each of the five pad slots, and its inverse.
    task automatic make_perm_pair(output logic [TABLE_W-1:0] fwd, output logic [TABLE_W-1:0] inv);
        logic [1:0] perm [4];
        logic [1:0] tmp;
        int         p;
        int         v;
        int         j;
        fwd = '0;
        inv = '0;
        for (p = 0; p < 5; p++) begin
            for (v = 0; v < 4; v++)
                perm[v] = 2'(v);
            for (v = 3; v > 0; v--) begin
                j       = $urandom_range(0, v);
                tmp     = perm[v];
                perm[v] = perm[j];
                perm[j] = tmp;
            end
            for (v = 0; v < 4; v++) begin
                fwd[8*p + 2*v +: 2]       = perm[v];
                inv[8*p + 2*perm[v] +: 2] = 2'(v);
            end
        end
    endtask

    // Random traffic until quota more counted items have gone in. Most of it is a
    // seed load followed by a run of blocks; some is a round trip that encrypts a run,
    // reloads the same seed and decrypts the cipher blocks; the rest is loose items
    // of any operation, reserved code included.
    task automatic run_phase(input int quota);
        int                stop_at;
        int                mode;
        int                n;
        int                i;
        logic [DATA_W-1:0] seed;
        logic [DATA_W-1:0] sealed[$];
        logic [OP_W-1:0]   op;
        out_item_t         res;
        stop_at = blocks_sent + quota;
        while (blocks_sent < stop_at) begin
            mode = $urandom_range(0, 99);
            seed = pick_word();
            n    = $urandom_range(1, 12);
            if (mode < 65) begin
                send_item(make_item(OP_LOAD_SEED, seed, 1'($urandom_range(0, 1))), 1'b0, '0, res);
                for (i = 0; i < n; i++) begin
                    op = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
                    send_item(make_item(op, pick_word(), i == n - 1), 1'b0, '0, res);
                end
            end else if (mode < 80) begin
                sealed.delete();
                send_item(make_item(OP_LOAD_SEED, seed, 1'b0), 1'b0, '0, res);
                for (i = 0; i < n; i++) begin
                    send_item(make_item(OP_ENCRYPT, pick_word(), i == n - 1), 1'b0, '0, res);
                    sealed.push_back(res.data_out);
                end
                send_item(make_item(OP_LOAD_SEED, seed, 1'b0), 1'b0, '0, res);
                for (i = 0; i < n; i++)
                    send_item(make_item(OP_DECRYPT, sealed[i], i == n - 1), 1'b0, '0, res);
            end else begin
                send_item(make_item(2'($urandom_range(0, 3)), $urandom(),
                                    1'($urandom_range(0, 1))), 1'b0, '0, res);
            end
        end
    endtask

    // The receiver stalls at random, in short bursts mostly and now and then for
    // a long stretch; in steady phases it starts no new stall.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each result block leaving the cipher is matched against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch($sformatf("result %h with none expected", m_item.data_out));
            end else begin
                want_block = pending_blocks.pop_front();
                if (m_item.data_out !== want_block.data_out)
                    report_mismatch($sformatf("data_out %h, expected %h",
                                              m_item.data_out, want_block.data_out));
                if (m_item.last_out !== want_block.last_out)
                    report_mismatch($sformatf("last_out %b, expected %b",
                                              m_item.last_out, want_block.last_out));
            end
        end
    end

    initial begin
        logic [TABLE_W-1:0] fwd;
        logic [TABLE_W-1:0] inv;
        out_item_t          res;
        int                 phase;

        // The directed rows run with the identity tables left by reset. While the
        // pad generator holds zero every pad word is zero, so encrypt and decrypt
        // both return the block untouched; those rows carry their answer.
        dir_rows = '{
            '{'{OP_ENCRYPT,   32'h0000_0000, 1'b0}, 1'b1, 32'h0000_0000},
            '{'{OP_ENCRYPT,   32'hFFFF_FFFF, 1'b1}, 1'b1, 32'hFFFF_FFFF},
            '{'{OP_DECRYPT,   32'hA5A5_A5A5, 1'b1}, 1'b1, 32'hA5A5_A5A5},
            // The reserved operation must neither answer nor step the pad generator.
            '{'{OP_RESERVED,  32'hFFFF_FFFF, 1'b1}, 1'b0, 32'h0},
            '{'{OP_DECRYPT,   32'h5A5A_5A5A, 1'b0}, 1'b1, 32'h5A5A_5A5A},
            '{'{OP_LOAD_SEED, 32'hFFFF_FFFF, 1'b1}, 1'b0, 32'h0},
            '{'{OP_ENCRYPT,   32'h0000_0000, 1'b0}, 1'b0, 32'h0},
            '{'{OP_DECRYPT,   32'hFFFF_FFFF, 1'b1}, 1'b0, 32'h0},
            '{'{OP_ENCRYPT,   32'h0F0F_0F0F, 1'b0}, 1'b0, 32'h0},
            '{'{OP_LOAD_SEED, 32'h8000_0001, 1'b0}, 1'b0, 32'h0},
            '{'{OP_ENCRYPT,   32'h5555_AAAA, 1'b0}, 1'b0, 32'h0},
            '{'{OP_DECRYPT,   32'h3333_CCCC, 1'b1}, 1'b0, 32'h0},
            '{'{OP_RESERVED,  32'h0000_0000, 1'b0}, 1'b0, 32'h0},
            '{'{OP_ENCRYPT,   32'h1234_5678, 1'b1}, 1'b0, 32'h0},
            // Reloading a zero seed brings back the all-zero pad.
            '{'{OP_LOAD_SEED, 32'h0000_0000, 1'b0}, 1'b0, 32'h0},
            '{'{OP_ENCRYPT,   32'h1234_5678, 1'b0}, 1'b1, 32'h1234_5678},
            '{'{OP_LOAD_SEED, 32'hDEAD_BEEF, 1'b1}, 1'b0, 32'h0},
            '{'{OP_DECRYPT,   32'h0000_0000, 1'b0}, 1'b0, 32'h0},
            '{'{OP_ENCRYPT,   32'hFFFF_FFFF, 1'b1}, 1'b0, 32'h0},
            '{'{OP_LOAD_SEED, 32'h0000_0001, 1'b0}, 1'b0, 32'h0},
            '{'{OP_ENCRYPT,   32'hC3C3_C3C3, 1'b1}, 1'b0, 32'h0}
        };

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_FORWARD;
        cfg_wdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want, res);

        // Each random phase starts from a new pair of tables: the all-zero and
        // all-one extremes, proper permutation pairs, arbitrary bit patterns and
        // the identity once more.
        for (phase = 1; phase <= 8; phase++) begin
            case (phase)
                1: begin
                    fwd = '0;
                    inv = '1;
                end
                2: begin
                    fwd = '1;
                    inv = '0;
                end
                4, 8: begin
                    fwd = {8'($urandom_range(0, 255)), 32'($urandom())};
                    inv = {8'($urandom_range(0, 255)), 32'($urandom())};
                end
                5: begin
                    fwd = TABLE_RESET;
                    inv = TABLE_RESET;
                end
                default: begin
                    make_perm_pair(fwd, inv);
                end
            endcase
            settle_and_configure(fwd, inv);
            steady = ($urandom_range(0, 3) == 0);
            run_phase(85);
        end

        s_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #TIMEOUT_NS;
        $display("tb: failure");
        $finish;
    end

endmodule
